// ----- src/rsse_pkg.sv -----
// Shared types, constants and GF(2^8) helpers for the Reed-Solomon encoder.
// No dependencies; every module of the encoder imports it.
package rsse_pkg;

   localparam int SYM_W      = 8;
   localparam int MAX_PARITY = 32;
   localparam logic [SYM_W:0]   FIELD_POLY = 9'h11D;
   localparam logic [SYM_W-1:0] PRIM_ELEM  = 8'h02;

   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      sym_type out_byte;
      logic    is_parity;
      logic    end_of_run;
      logic    end_of_codeword;
   } rsp_item_type;

   // GF(2^8) multiply; folds to a small xor network when one side is constant.
   function automatic sym_type gf_mul(input sym_type x, input sym_type y);
      logic [SYM_W:0]   a;
      logic [SYM_W-1:0] b;
      sym_type          acc;
      a   = {1'b0, x};
      b   = y;
      acc = '0;
      for (int i = 0; i < SYM_W; i++) begin
         if (b[0]) begin
            acc = acc ^ a[SYM_W-1:0];
         end
         b = b >> 1;
         a = a << 1;
         if (a[SYM_W]) begin
            a = a ^ FIELD_POLY;
         end
      end
      return acc;
   endfunction

   // Coefficient idx of g(x) = (x+a^0)...(x+a^(plen-1)); elaboration time only.
   function automatic sym_type gen_coef(input int plen, input int idx);
      sym_type g [0:MAX_PARITY];
      sym_type root;
      for (int k = 0; k <= MAX_PARITY; k++) begin
         g[k] = '0;
      end
      g[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < plen; i++) begin
         for (int j = i + 1; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
         root = gf_mul(root, PRIM_ELEM);
      end
      return g[idx];
   endfunction

endpackage

// ----- src/reed_solomon_systematic_encoder_core.sv -----
// Systematic RS encoder over GF(2^8), poly 0x11D, generator roots a^0..a^(PARITY_LEN-1).
// Depends on rsse_pkg, rsse_cell and rsse_out_stage.
//
// Usage:
//  - req channel: one data byte per item (req_data_byte), valid/stall handshake.
//  - rsp channel: each data byte is echoed through the output register once it is taken
//    (is_parity = 0). After the DATA_LEN-th byte of a block the PARITY_LEN
//    parity symbols follow, highest degree first; the last one carries
//    end_of_run and end_of_codeword.
//  - Throughput: one data item per cycle while req_stall is low. While a block's
//    parity drains, req_stall stays high: the cell chain shifts one symbol out
//    of its top cell per cycle unless the skid buffer is full, and clears itself
//    in doing so.
//  - rsp_stall: results park in the output register and a one-entry skid
//    buffer; once the skid fills, req_stall rises until it drains.
//  - Reset (synchronous): remainder cells, block count and output stage clear;
//    the next byte starts a new block. Short final blocks are zero padded by
//    the host.
module reed_solomon_systematic_encoder_core #(
   parameter int DATA_LEN   = 223,
   parameter int PARITY_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsse_pkg::sym_type req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsse_pkg::sym_type rsp_out_byte,
   output logic              rsp_is_parity,
   output logic              rsp_end_of_run,
   output logic              rsp_end_of_codeword
);
   import rsse_pkg::*;

   localparam int CNT_W   = $clog2(DATA_LEN + 1);
   localparam int DRAIN_W = $clog2(PARITY_LEN);

   logic               draining_ff, draining_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DRAIN_W-1:0] drain_cnt_ff, drain_cnt_in;

   sym_type      cell_q [PARITY_LEN];
   sym_type      feedback;
   logic         accept_req, drain_step, produce, last_data, final_par, skid_full;
   rsp_item_type prod_item, out_item;

   assign req_stall  = draining_ff || skid_full;
   assign accept_req = req_valid && !req_stall;
   assign drain_step = draining_ff && !skid_full;
   assign produce    = accept_req || drain_step;
   assign last_data  = (count_ff == CNT_W'(DATA_LEN - 1));
   assign final_par  = (drain_cnt_ff == DRAIN_W'(PARITY_LEN - 1));
   assign feedback   = draining_ff ? '0 : (req_data_byte ^ cell_q[PARITY_LEN-1]);

   for (genvar j = 0; j < PARITY_LEN; j++) begin : g_cell
      sym_type prev;
      if (j == 0) begin : g_first
         assign prev = '0;
      end else begin : g_rest
         assign prev = cell_q[j-1];
      end
      rsse_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (produce),
         .coef     (gen_coef(PARITY_LEN, j)),
         .feedback (feedback),
         .prev_sym (prev),
         .sym_q    (cell_q[j])
      );
   end

   always_comb begin
      if (draining_ff) begin
         prod_item.out_byte        = cell_q[PARITY_LEN-1];
         prod_item.is_parity       = 1'b1;
         prod_item.end_of_run      = final_par;
         prod_item.end_of_codeword = final_par;
      end else begin
         prod_item.out_byte        = req_data_byte;
         prod_item.is_parity       = 1'b0;
         prod_item.end_of_run      = !last_data;
         prod_item.end_of_codeword = 1'b0;
      end
   end

   always_comb begin
      draining_in  = draining_ff;
      count_in     = count_ff;
      drain_cnt_in = drain_cnt_ff;
      if (accept_req) begin
         if (last_data) begin
            count_in    = '0;
            draining_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (drain_step) begin
         if (final_par) begin
            drain_cnt_in = '0;
            draining_in  = 1'b0;
         end else begin
            drain_cnt_in = drain_cnt_ff + DRAIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff  <= 1'b0;
         count_ff     <= '0;
         drain_cnt_ff <= '0;
      end else begin
         draining_ff  <= draining_in;
         count_ff     <= count_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   rsse_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (produce),
      .in_item   (prod_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (out_item),
      .full      (skid_full)
   );

   assign rsp_out_byte        = out_item.out_byte;
   assign rsp_is_parity       = out_item.is_parity;
   assign rsp_end_of_run      = out_item.end_of_run;
   assign rsp_end_of_codeword = out_item.end_of_codeword;

endmodule

// ----- src/rsse_cell.sv -----
// One stage of the parity division chain: holds one remainder symbol.
// Depends on rsse_pkg for the symbol type and gf_mul.
module rsse_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  rsse_pkg::sym_type coef,
   input  rsse_pkg::sym_type feedback,
   input  rsse_pkg::sym_type prev_sym,
   output rsse_pkg::sym_type sym_q
);
   import rsse_pkg::*;

   sym_type sym_ff;
   sym_type sym_in;

   // feedback is zero while parity drains, so the chain just shifts up
   assign sym_in = prev_sym ^ gf_mul(coef, feedback);

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
      end else if (shift_en) begin
         sym_ff <= sym_in;
      end
   end

   assign sym_q = sym_ff;

endmodule

// ----- src/rsse_out_stage.sv -----
// Output register with a one-entry skid buffer for the result channel.
// Depends on rsse_pkg for the result item struct.
module rsse_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rsse_pkg::rsp_item_type in_item,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsse_pkg::rsp_item_type rsp_item,
   output logic                  full
);
   import rsse_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // producer only offers an item while the skid entry is empty
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_item_in  = in_item;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;
   assign full      = skid_valid_ff;

endmodule

// ----- src/rsse_checker.sv -----
// Port-level checks for the Reed-Solomon encoder, bound to the top level.
// Depends on rsse_pkg for the symbol type.
module rsse_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsse_pkg::sym_type rsp_out_byte,
   input logic              rsp_is_parity,
   input logic              rsp_end_of_run,
   input logic              rsp_end_of_codeword
);
   import rsse_pkg::*;

   // codeword end only on the final parity symbol
   a_eoc_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_codeword |-> rsp_is_parity && rsp_end_of_run)
      else $error("end_of_codeword on a result that is not the final parity item");

   // parity drains without gaps once it has started
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_is_parity && !rsp_end_of_run |=> rsp_valid)
      else $error("gap in parity drain");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_parity) && $stable(rsp_end_of_run))
      else $error("stalled result item changed");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind reed_solomon_systematic_encoder_core rsse_checker u_rsse_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_is_parity       (rsp_is_parity),
   .rsp_end_of_run      (rsp_end_of_run),
   .rsp_end_of_codeword (rsp_end_of_codeword)
);

// ----- tb/reed_solomon_systematic_encoder_core_tb.sv -----
// Self-checking bench for reed_solomon_systematic_encoder_core: a directed table, then random
// bytes, with random idling on both channels, checked against a GF(2^8) LFSR parity predictor.
// Depends on rsse_pkg (symbol and result types, field polynomial) and the encoder RTL.
`timescale 1ns / 1ps

module reed_solomon_systematic_encoder_core_tb;

   import rsse_pkg::*;

   // Full-size code; the run closes one codeword and ends partway into the next.
   localparam int DATA_LEN     = 223;
   localparam int PARITY_LEN   = 32;
   localparam int RAND_ITEMS   = 213;
   localparam int QUIET_ITEMS  = 5;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG     = 1000;
   localparam sym_type POLY_LOW = FIELD_POLY[SYM_W-1:0];

   typedef struct {
      sym_type data;
      bit      typed;      // expectation written in the row
      bit      eor;        // typed echo end_of_run; 0 means a zero codeword closes here
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   sym_type req_data_byte = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   sym_type rsp_out_byte;
   logic    rsp_is_parity;
   logic    rsp_end_of_run;
   logic    rsp_end_of_codeword;

   sym_type      gen_c [0:PARITY_LEN];
   sym_type      rem_q [PARITY_LEN];
   int unsigned  blk_count;
   rsp_item_type symbol_q [$];

   int  err_count  = 0;
   int  n_items    = 0;
   int  n_syms     = 0;
   int  n_words    = 0;
   int  stall_left = 0;
   bit  quiet      = 1'b0;

   stim_row_type dir_tab [17] = '{
      '{8'h00, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1},
      '{8'hFF, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h55, 1'b0, 1'b0},
      '{8'hAA, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b1}, '{8'hFF, 1'b1, 1'b1}, '{8'h7E, 1'b0, 1'b0}
   };

   reed_solomon_systematic_encoder_core #(
      .DATA_LEN   (DATA_LEN),
      .PARITY_LEN (PARITY_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_is_parity       (rsp_is_parity),
      .rsp_end_of_run      (rsp_end_of_run),
      .rsp_end_of_codeword (rsp_end_of_codeword)
   );

   always #5 clock = ~clock;

   // GF(2^8) product, bit-serial over b with xtime steps on a.
   function automatic sym_type gf_times(input sym_type a, input sym_type b);
      sym_type p;
      sym_type x;
      p = '0;
      x = a;
      for (int i = 0; i < SYM_W; i++) begin
         if (b[i]) begin
            p = p ^ x;
         end
         x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? POLY_LOW : '0);
      end
      return p;
   endfunction

   // Shift one byte through the parity LFSR; queue the echo and, at block end, the parity.
   task automatic encode_byte(input sym_type b, input bit record);
      sym_type fb;
      bit      last;
      bit      fin;
      fb = b ^ rem_q[PARITY_LEN-1];
      for (int j = PARITY_LEN - 1; j > 0; j--) begin
         rem_q[j] = rem_q[j-1] ^ gf_times(gen_c[j], fb);
      end
      rem_q[0]  = gf_times(gen_c[0], fb);
      blk_count = (blk_count + 1) & 8'hFF;
      last      = (blk_count >= DATA_LEN);
      if (record) begin
         symbol_q.push_back('{b, 1'b0, !last, 1'b0});
      end
      if (last) begin
         for (int k = 0; k < PARITY_LEN; k++) begin
            fin = (k == PARITY_LEN - 1);
            if (record) begin
               symbol_q.push_back('{rem_q[PARITY_LEN-1-k], 1'b1, fin, fin});
            end
         end
         foreach (rem_q[j]) begin
            rem_q[j] = '0;
         end
         blk_count = 0;
      end
   endtask

   // Returns at the edge where the item is taken.
   task automatic send_byte(input sym_type b);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      n_items++;
   endtask

   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req_valid     <= 1'b0;
         req_data_byte <= sym_type'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9);
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_syms++;
         if (symbol_q.size() == 0) begin
            $error("unexpected item: out_byte %02h is_parity %0b", rsp_out_byte, rsp_is_parity);
            err_count++;
         end else begin
            want = symbol_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
               err_count++;
            end
            if (rsp_is_parity !== want.is_parity) begin
               $error("is_parity: expected %0b, got %0b", want.is_parity, rsp_is_parity);
               err_count++;
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %0b, got %0b", want.end_of_run, rsp_end_of_run);
               err_count++;
            end
            if (rsp_end_of_codeword !== want.end_of_codeword) begin
               $error("end_of_codeword: expected %0b, got %0b",
                      want.end_of_codeword, rsp_end_of_codeword);
               err_count++;
            end
            if (want.end_of_codeword) begin
               n_words++;
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      sym_type root;
      sym_type b;
      int      pick;
      foreach (gen_c[k]) begin
         gen_c[k] = '0;
      end
      gen_c[0] = 8'h01;
      root     = 8'h01;
      for (int i = 0; i < PARITY_LEN; i++) begin
         for (int j = i + 1; j > 0; j--) begin
            gen_c[j] = gen_c[j-1] ^ gf_times(gen_c[j], root);
         end
         gen_c[0] = gf_times(gen_c[0], root);
         root     = gf_times(root, PRIM_ELEM);
      end
      foreach (rem_q[j]) begin
         rem_q[j] = '0;
      end
      blk_count = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[r]) begin
         send_byte(dir_tab[r].data);
         if (dir_tab[r].typed) begin
            encode_byte(dir_tab[r].data, 1'b0);
            symbol_q.push_back('{dir_tab[r].data, 1'b0, dir_tab[r].eor, 1'b0});
            if (!dir_tab[r].eor) begin
               // all-zero block: every parity symbol is zero
               for (int k = 0; k < PARITY_LEN; k++) begin
                  symbol_q.push_back('{8'h00, 1'b1, k == PARITY_LEN - 1, k == PARITY_LEN - 1});
               end
            end
         end else begin
            encode_byte(dir_tab[r].data, 1'b1);
         end
         sender_gap();
      end

      // hold off mid-block until the output side has caught up
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (symbol_q.size() != 0);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i >= RAND_ITEMS - QUIET_ITEMS) begin
            quiet = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            b = 8'h00;
         end else if (pick == 1) begin
            b = 8'hFF;
         end else begin
            b = sym_type'($urandom);
         end
         send_byte(b);
         encode_byte(b, 1'b1);
         sender_gap();
      end
      req_valid <= 1'b0;

      while (symbol_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run sent %0d data bytes and checked %0d output symbols over %0d codewords",
               n_items, n_syms, n_words);
      $display("with random gaps and stalls on both channels and a mid-block hold-off.");
      if (err_count == 0 && symbol_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/rsse_pkg.sv
src/rsse_cell.sv
src/rsse_out_stage.sv
src/reed_solomon_systematic_encoder_core.sv
src/rsse_checker.sv
tb/reed_solomon_systematic_encoder_core_tb.sv
